### src/irs_pkg.sv
// Shared types, constants and register codes for the image rotate sampler.
package irs_pkg;

  localparam int MaxSide  = 64;
  localparam int IdxW     = $clog2(MaxSide);
  localparam int AddrW    = 2 * IdxW;
  localparam int Depth    = MaxSide * MaxSide;
  localparam int CoordW   = 6;
  localparam int PixW     = 16;
  localparam int FactW    = 16;
  localparam int SideW    = 7;
  localparam int FracW    = 14;
  localparam int DiffW    = CoordW + 3;
  localparam int ProdW    = DiffW + FactW;
  localparam int QW       = ProdW + 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);

  typedef enum logic [CfgIdxW-1:0] {
    CfgCos    = 2'd0,
    CfgNegSin = 2'd1,
    CfgSide   = 2'd2,
    CfgFill   = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    FuncWrite  = 1'b0,
    FuncSample = 1'b1
  } func_e;

  typedef struct packed {
    logic signed [FactW-1:0] cos_f;
    logic signed [FactW-1:0] nsin_f;
    logic [SideW-1:0]        side;
    logic [PixW-1:0]         fill;
  } cfg_t;

  typedef struct packed {
    logic             is_write;
    logic [AddrW-1:0] addr;
    logic [PixW-1:0]  pixel;
    logic             outside;
  } op_t;

endpackage

### src/image_rotate_sampler_top.sv
// Top level of the nearest-neighbor image rotate sampler.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | func, coord_row, coord_col, pixel_in
//  out     | output    | out_valid/out_ready | pixel_out, outside
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A sample is registered in the front stage, the queue, the store read and the output register;
// a new sample read is not issued while the previous read is still pending, set by the single store
// port and its registered read. Writes use the store port without waiting on the output.
// Reset clears only control state; the image store holds garbage until written.
// A four-entry queue lets the front keep accepting while the output stalls.
module image_rotate_sampler_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         func_i,
  input  logic [irs_pkg::CoordW-1:0]   coord_row_i,
  input  logic [irs_pkg::CoordW-1:0]   coord_col_i,
  input  logic [irs_pkg::PixW-1:0]     pixel_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [irs_pkg::PixW-1:0]     pixel_out_o,
  output logic                         outside_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [irs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [irs_pkg::CfgDataW-1:0] cfg_data_i
);
  import irs_pkg::*;

  cfg_t cfg_q;
  logic push, q_full, q_pop, q_valid;
  op_t  push_op, q_head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cos_f  <= FactW'(16384);
      cfg_q.nsin_f <= '0;
      cfg_q.side   <= SideW'(50);
      cfg_q.fill   <= '1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgCos:    cfg_q.cos_f  <= cfg_data_i;
        CfgNegSin: cfg_q.nsin_f <= cfg_data_i;
        CfgSide:   cfg_q.side   <= cfg_data_i[SideW-1:0];
        CfgFill:   cfg_q.fill   <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  irs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .coord_row_i(coord_row_i),
    .coord_col_i(coord_col_i),
    .pixel_in_i (pixel_in_i),
    .push_o     (push),
    .push_op_o  (push_op),
    .q_full_i   (q_full)
  );

  irs_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .push_op_i(push_op),
    .full_o   (q_full),
    .pop_i    (q_pop),
    .valid_o  (q_valid),
    .head_o   (q_head)
  );

  irs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fill_i     (cfg_q.fill),
    .q_valid_i  (q_valid),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .pixel_out_o(pixel_out_o),
    .outside_o  (outside_o)
  );

endmodule

### src/irs_ram.sv
// Generic single-port RAM with registered read.
module irs_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/irs_front.sv
// Front end: accepts transactions, computes rotated source address, classifies.
module irs_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  irs_pkg::cfg_t             cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      func_i,
  input  logic [irs_pkg::CoordW-1:0] coord_row_i,
  input  logic [irs_pkg::CoordW-1:0] coord_col_i,
  input  logic [irs_pkg::PixW-1:0]  pixel_in_i,
  output logic                      push_o,
  output irs_pkg::op_t              push_op_o,
  input  logic                      q_full_i
);
  import irs_pkg::*;

  logic [SideW-1:0]        side_eff;
  logic signed [DiffW-1:0] du, dv;
  logic signed [ProdW-1:0] p_us, p_uc, p_vc, p_vs;

  logic                    s1_valid_q;
  logic                    s1_write_q;
  logic [CoordW-1:0]       s1_row_q, s1_col_q;
  logic [PixW-1:0]         s1_pix_q;
  logic signed [ProdW-1:0] s1_us_q, s1_uc_q, s1_vc_q, s1_vs_q;

  logic signed [QW-1:0]    base, qx, qy;
  logic                    ok_x, ok_y, wr_ok, drop, advance, accept;
  logic [IdxW-1:0]         src_col, src_row;

  assign side_eff = (int'(cfg_i.side) > MaxSide) ? SideW'(MaxSide) : cfg_i.side;

  assign du = $signed({2'b00, coord_row_i, 1'b0}) - $signed({2'b00, side_eff});
  assign dv = $signed({2'b00, coord_col_i, 1'b0}) - $signed({2'b00, side_eff});

  assign p_us = du * cfg_i.nsin_f;
  assign p_uc = du * cfg_i.cos_f;
  assign p_vc = dv * cfg_i.cos_f;
  assign p_vs = dv * cfg_i.nsin_f;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_write_q <= (func_e'(func_i) == FuncWrite);
      s1_row_q   <= coord_row_i;
      s1_col_q   <= coord_col_i;
      s1_pix_q   <= pixel_in_i;
      s1_us_q    <= p_us;
      s1_uc_q    <= p_uc;
      s1_vc_q    <= p_vc;
      s1_vs_q    <= p_vs;
    end
  end

  // Source position scaled by 2^15, centered on side/2.
  assign base = $signed({{(QW-SideW-FracW){1'b0}}, side_eff, {FracW{1'b0}}});
  assign qx   = base + QW'(s1_us_q) + QW'(s1_vc_q);
  assign qy   = base + QW'(s1_uc_q) - QW'(s1_vs_q);

  // Truncation toward zero: (-1,0) maps to column/row zero.
  always_comb begin
    if (qx[QW-1]) begin
      ok_x    = (qx > -$signed(QW'(32768))) && (side_eff != '0);
      src_col = '0;
    end else begin
      ok_x    = qx[QW-2:15] < (QW-16)'(side_eff);
      src_col = qx[15 +: IdxW];
    end
    if (qy[QW-1]) begin
      ok_y    = (qy > -$signed(QW'(32768))) && (side_eff != '0);
      src_row = '0;
    end else begin
      ok_y    = qy[QW-2:15] < (QW-16)'(side_eff);
      src_row = qy[15 +: IdxW];
    end
  end

  assign wr_ok = (int'(s1_row_q) < MaxSide) && (int'(s1_col_q) < MaxSide);
  assign drop  = s1_valid_q && s1_write_q && !wr_ok;
  assign push_o  = s1_valid_q && !drop && !q_full_i;
  assign advance = push_o || drop;

  always_comb begin
    push_op_o.is_write = s1_write_q;
    push_op_o.pixel    = s1_pix_q;
    if (s1_write_q) begin
      push_op_o.addr    = {s1_row_q[IdxW-1:0], s1_col_q[IdxW-1:0]};
      push_op_o.outside = 1'b0;
    end else begin
      push_op_o.addr    = {src_row, src_col};
      push_op_o.outside = !(ok_x && ok_y);
    end
  end

endmodule

### src/irs_queue.sv
// Small FIFO of classified operations between front and back.
module irs_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  irs_pkg::op_t push_op_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output irs_pkg::op_t head_o
);
  import irs_pkg::*;

  op_t              slot_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   cnt_q;

  assign full_o  = (int'(cnt_q) == QDepth);
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

### src/irs_back.sv
// Back end: image store access and output register.
module irs_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [irs_pkg::PixW-1:0] fill_i,
  input  logic                     q_valid_i,
  input  irs_pkg::op_t             q_head_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [irs_pkg::PixW-1:0] pixel_out_o,
  output logic                     outside_o
);
  import irs_pkg::*;

  logic            rd_pend_q, rd_out_q;
  logic            out_valid_q, out_outside_q;
  logic [PixW-1:0] out_pixel_q;
  logic [PixW-1:0] rdata;
  logic            slot_free, do_write, do_read;

  assign slot_free = !out_valid_q || out_ready_i;
  assign do_write  = q_valid_i && q_head_i.is_write;
  assign do_read   = q_valid_i && !q_head_i.is_write && !rd_pend_q && slot_free;
  assign q_pop_o   = do_write || do_read;

  irs_ram #(
    .Width(PixW),
    .Depth(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (do_write),
    .re_i   (do_read),
    .addr_i (q_head_i.addr),
    .wdata_i(q_head_i.pixel),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= do_read;
      if (rd_pend_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_read) begin
      rd_out_q <= q_head_i.outside;
    end
    if (rd_pend_q) begin
      out_pixel_q   <= rd_out_q ? fill_i : rdata;
      out_outside_q <= rd_out_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = out_pixel_q;
  assign outside_o   = out_outside_q;

endmodule
